@@ hdl/isort_pkg.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// isort_pkg
// shared constants, controller states and the control/status bundles of the
// insertion sorter
// -----------------------------------------------------------------------------
package isort_pkg;

	// fixed width of the value and sorted_value ports
	localparam int VALUE_W = 32;

	// defaults for the top level parameters
	localparam int MAX_ITEMS_DEF  = 32;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [0:0] {
		ST_LOAD,
		ST_EMIT
	} isort_state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic insert;
		logic drain;
	} isort_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic one_left;
	} isort_stat_t;

endpackage
`default_nettype wire

@@ hdl/isort_datapath.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// isort_datapath
// compare-and-shift cell chain that holds the ascending set, plus the
// registered result port
// -----------------------------------------------------------------------------
module isort_datapath import isort_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  isort_cmd_t               cmd,
	input  wire  [VALUE_W-1:0]       value,
	output isort_stat_t              stat,
	output logic                     strobe,
	output logic [VALUE_W-1:0]       sorted_value,
	output logic                     final_res,
	output logic                     overflow
);

	localparam int COUNT_W = $clog2(MAX_ITEMS + 1);

	logic [DATA_WIDTH-1:0] entry_q [MAX_ITEMS];
	logic [DATA_WIDTH-1:0] entry_nxt [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]  gt;
	logic [COUNT_W-1:0]    count_q;
	logic                  dropped_q;
	logic                  room;
	logic [DATA_WIDTH+VALUE_W-1:0] in_wide;
	logic [DATA_WIDTH+VALUE_W-1:0] out_wide;
	logic [DATA_WIDTH-1:0] ins;

	// value is zero-extended or truncated to the store width
	assign in_wide  = {{DATA_WIDTH{1'b0}}, value};
	assign ins      = in_wide[DATA_WIDTH-1:0];
	assign out_wide = {{VALUE_W{1'b0}}, entry_q[0]};

	assign room          = (count_q < COUNT_W'(MAX_ITEMS));
	assign stat.one_left = (count_q == COUNT_W'(1));

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			// empty cells act as plus infinity
			assign gt[i] = (COUNT_W'(i) >= count_q) ||
				($signed(entry_q[i]) > $signed(ins));

			if (i == 0) begin : g_first
				assign entry_nxt[i] = gt[i] ? ins : entry_q[i];
			end else begin : g_rest
				assign entry_nxt[i] = !gt[i] ? entry_q[i] :
					(gt[i-1] ? entry_q[i-1] : ins);
			end

			always_ff @(posedge clk) begin
				if (cmd.insert && room) begin
					entry_q[i] <= entry_nxt[i];
				end else if (cmd.drain) begin
					if (i < MAX_ITEMS - 1) begin
						entry_q[i] <= entry_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			strobe    <= 1'b0;
		end else begin
			strobe <= cmd.drain;
			if (cmd.insert) begin
				if (room) begin
					count_q <= count_q + COUNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end else if (cmd.drain) begin
				count_q <= count_q - COUNT_W'(1);
				if (stat.one_left) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			sorted_value <= out_wide[VALUE_W-1:0];
			final_res    <= stat.one_left;
			overflow     <= dropped_q;
		end
	end

endmodule
`default_nettype wire

@@ hdl/isort_ctrl.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// isort_ctrl
// load/emit sequencer of the insertion sorter
// -----------------------------------------------------------------------------
module isort_ctrl import isort_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire         last,
	input  isort_stat_t stat,
	output isort_cmd_t  cmd,
	output logic        busy
);

	isort_state_t state_q;
	isort_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		cmd.insert = 1'b0;
		cmd.drain  = 1'b0;
		busy       = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.insert = start;
				if (start && last) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				busy      = 1'b1;
				cmd.drain = 1'b1;
				if (stat.one_left) begin
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/insertion_sorter.sv @@
`default_nettype none
// -----------------------------------------------------------------------------
// insertion_sorter
// streaming insertion sorter: collects a set of signed values and returns
// them in ascending order
// -----------------------------------------------------------------------------
// usage
//   input beat: value and last are taken at a rising edge with start high
//   and busy low. each value is inserted at the accepting edge into a chain of
//   compare-and-shift cells, so beats may follow each other every cycle
//   while busy is low. equal values keep their arrival order.
//   the beat with last high closes the set: busy rises in the next cycle
//   and stays high until every stored value has been read out.
//   result beats: the first result is loaded into the result register
//   while busy is high, then one result per cycle, each held for exactly
//   one cycle with strobe high. final_res marks the last one, overflow is
//   set on every result of a set in which beats beyond MAX_ITEMS were
//   dropped. the receiver cannot stall, results are never held back.
//   the readout rate is set by the cell chain shifting down one place per
//   cycle; a new set may start in the cycle that carries the final result.
//   reset: asynchronous, clears the fill count, the drop flag, the strobe
//   and the sequencer; no clearing pass, the cells are written before read
// -----------------------------------------------------------------------------
module insertion_sorter import isort_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire  [VALUE_W-1:0] value,
	input  wire                last,
	output logic               strobe,
	output logic [VALUE_W-1:0] sorted_value,
	output logic               final_res,
	output logic               overflow
);

	// controller to datapath commands and status back
	isort_cmd_t  cmd;
	isort_stat_t stat;

	isort_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.last   (last),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// cell chain and result register
	isort_datapath #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.stat         (stat),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

	// results only come out of a readout phase
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without readout phase");

	// the final result ends the readout phase
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && final_res |-> !busy)
		else $error("readout still busy at final result");

	// a result that is not the final one is followed by more
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !final_res |-> busy)
		else $error("readout ended before final result");

	// closing beat starts the readout
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("last beat did not start readout");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// self-checking bench for the insertion sorter: sets of signed values go in
// through the start/busy handshake, and every sorted result beat is compared
// against a shadow sorter held in a small scoreboard
// -----------------------------------------------------------------------------
module tb_top;
	import isort_pkg::*;

	// the shadow sorter assumes the default sizes of the block
	localparam int CAP         = MAX_ITEMS_DEF;
	localparam int RAND_BEATS  = 250;
	localparam int TAIL_CYCLES = 8;
	// worst case is far below this: ~320 beats, each after an idle gap,
	// plus up to 32 result beats per set and the drain waits
	localparam int CYCLE_LIMIT = 200000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value;
	logic               last;
	logic               strobe;
	logic [VALUE_W-1:0] sorted_value;
	logic               final_res;
	logic               overflow;

	int cycles = 0;

	// one expected result beat
	typedef struct {
		logic signed [VALUE_W-1:0] val;
		logic                      fin;
		logic                      ovf;
	} sorted_beat_t;

	// scoreboard: keeps a shadow copy of the set being collected and the
	// queue of result beats still owed by the block
	class sort_checker;
		logic signed [VALUE_W-1:0] held[$];
		bit                        dropped;
		sorted_beat_t              owed[$];
		int                        errors;

		// an input beat was accepted: insert it, and on last queue the run
		function void take_value(logic signed [VALUE_W-1:0] v, logic l);
			int           pos;
			sorted_beat_t b;
			if (held.size() >= CAP) begin
				dropped = 1'b1;
			end else begin
				// strictly greater entries move up, equal values keep order
				pos = held.size();
				while (pos > 0 && held[pos-1] > v)
					pos--;
				held.insert(pos, v);
			end
			if (l) begin
				foreach (held[k]) begin
					b.val = held[k];
					b.fin = (k == held.size() - 1);
					b.ovf = dropped;
					owed.push_back(b);
				end
				held.delete();
				dropped = 1'b0;
			end
		endfunction

		// a result beat was seen: compare it with the oldest one owed
		function void check_result(logic signed [VALUE_W-1:0] v, logic f, logic o);
			sorted_beat_t want;
			if (owed.size() == 0) begin
				$error("result beat with nothing owed: sorted_value %0d", v);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (v !== want.val) begin
				$error("sorted_value: expected %0d, got %0d", want.val, v);
				errors++;
			end
			if (f !== want.fin) begin
				$error("final_res: expected %0b, got %0b", want.fin, f);
				errors++;
			end
			if (o !== want.ovf) begin
				$error("overflow: expected %0b, got %0b", want.ovf, o);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	sort_checker chk;

	// directed sets: single beats at the extremes and zero, a mixed set with
	// both extremes, alternating bit patterns and repeats, an already
	// ascending set, and a set of equal values
	logic [VALUE_W-1:0] dir_val [22] = '{
		32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
		32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001,
		32'h0000_0005, 32'h0000_0005, 32'hffff_fffb, 32'h5555_5555, 32'haaaa_aaaa,
		32'hffff_ffff,
		32'hffff_fffd, 32'hffff_fffe, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001,
		32'h0000_0007, 32'h0000_0007, 32'h0000_0007
	};
	bit dir_last [22] = '{
		1, 1, 1,
		0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
		0, 0, 0, 0, 1,
		0, 0, 1
	};

	insertion_sorter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.last         (last),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.overflow     (overflow)
	);

	always #10 clk = ~clk;

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: the receiver can't stall, every strobe is one beat
	always @(posedge clk) begin
		if (arst_n && strobe)
			chk.check_result(sorted_value, final_res, overflow);
	end

	// mostly full-range values, some small ones so repeats are common,
	// some at the edges of the signed range
	function automatic logic [VALUE_W-1:0] pick_value();
		int s;
		case ($urandom_range(0, 7))
			0: begin
				s = $urandom_range(0, 3);
				if (s == 0)
					return 32'h8000_0000;
				else if (s == 1)
					return 32'h7fff_ffff;
				else if (s == 2)
					return 32'hffff_ffff;
				else
					return 32'h0000_0000;
			end
			1, 2: begin
				s = $urandom_range(0, 16);
				return VALUE_W'(s - 8);
			end
			default: return $urandom();
		endcase
	endfunction

	// one input beat: idle for the given gap, then hold start until the block
	// takes it; with no gap start stays high from the previous beat
	task automatic send_beat(input logic [VALUE_W-1:0] v, input logic l, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		last  <= l;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		chk.take_value(v, l);
	endtask

	// stop sending and wait until every owed result has come back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (chk.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int n;
		int gap;
		int sent;
		bit burst;
		chk    = new();
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		last   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, mostly back to back
		foreach (dir_val[i])
			send_beat(dir_val[i], dir_last[i], (i % 4 == 3) ? $urandom_range(0, 10) : 0);
		wait_drained();

		// random sets; the first one overruns the store so the drop path is
		// always exercised, later ones are mostly small with a few full or
		// overrunning sets
		sent = 0;
		while (sent < RAND_BEATS) begin
			if (sent == 0) begin
				n = CAP + $urandom_range(1, 8);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: n = $urandom_range(1, 8);
					6, 7:             n = $urandom_range(9, CAP - 1);
					8:                n = CAP;
					default:          n = CAP + $urandom_range(1, 8);
				endcase
			end
			// some sets stream with no idle cycles at all
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n; i++) begin
				gap = burst ? 0 : $urandom_range(0, 10);
				send_beat(pick_value(), i == n - 1, gap);
			end
			sent += n;
			// now and then let the block go fully idle before the next set
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (chk.errors == 0 && chk.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/isort_pkg.sv
hdl/isort_datapath.sv
hdl/isort_ctrl.sv
hdl/insertion_sorter.sv
dv/tb_top.sv
